// ===== hdl/mlfq_pkg.sv =====
// shared types and constants of the feedback queue scheduler
package mlfq_pkg;

    localparam int ID_W       = 4;
    localparam int BURST_W    = 16;
    localparam int SLICE_W    = 8;
    localparam int TICK_W     = 16;
    localparam int LVL_W      = 2;
    localparam int NUM_LEVELS = 3;
    localparam int MOD_CNT_W  = 5;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int S_DATA_W   = 24;
    localparam int M_DATA_W   = 32;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SLICE0 = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SLICE1 = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SLICE2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BOOST  = 2'd3;

    // priority levels
    localparam logic [LVL_W-1:0] LVL0 = 2'd0;
    localparam logic [LVL_W-1:0] LVL1 = 2'd1;
    localparam logic [LVL_W-1:0] LVL2 = 2'd2;

    // request kinds on tuser
    localparam logic MODE_ARRIVE = 1'b0;
    localparam logic MODE_TICK   = 1'b1;

    // datapath operations
    typedef logic [3:0] t_op;
    localparam t_op OP_NONE      = 4'd0;
    localparam t_op OP_ARRIVE    = 4'd1;
    localparam t_op OP_MOD_INIT  = 4'd2;
    localparam t_op OP_MOD_STEP  = 4'd3;
    localparam t_op OP_BOOST_RD  = 4'd4;
    localparam t_op OP_BOOST_WR  = 4'd5;
    localparam t_op OP_BOOST_FIX = 4'd6;
    localparam t_op OP_PREEMPT   = 4'd7;
    localparam t_op OP_PICK_RD   = 4'd8;
    localparam t_op OP_PICK_LD   = 4'd9;
    localparam t_op OP_WL_RD     = 4'd10;
    localparam t_op OP_RUN       = 4'd11;
    localparam t_op OP_OUT_LOAD  = 4'd12;

    typedef struct packed {
        t_op op;
    } t_cmd;

    typedef struct packed {
        logic                  mod_done;
        logic                  boost;
        logic [NUM_LEVELS-1:0] nonempty;
        logic                  run_valid;
        logic                  out_free;
    } t_status;

    // result item, last field in the lowest bits
    typedef struct packed {
        logic [TICK_W-1:0] tick_time;
        logic              boosted;
        logic              preempted;
        logic              demoted;
        logic              finished;
        logic [LVL_W-1:0]  run_level;
        logic [ID_W-1:0]   run_id;
        logic              cpu_busy;
        logic              accepted;
    } t_result;

endpackage

// ===== hdl/mlfq_ctrl.sv =====
// sequencing state machine of the feedback queue scheduler
module mlfq_ctrl import mlfq_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  logic    i_in_mode,
    input  t_status i_status,
    output logic    o_in_ready,
    output t_cmd    o_cmd
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_MOD   = 4'd1;
    localparam logic [3:0] S_BOOST = 4'd2;
    localparam logic [3:0] S_BWR   = 4'd3;
    localparam logic [3:0] S_PRE   = 4'd4;
    localparam logic [3:0] S_PICK  = 4'd5;
    localparam logic [3:0] S_PLD   = 4'd6;
    localparam logic [3:0] S_WRD   = 4'd7;
    localparam logic [3:0] S_RUN   = 4'd8;
    localparam logic [3:0] S_OUT   = 4'd9;

    logic [3:0] r_state, n_state;

    assign o_in_ready = (r_state == S_IDLE);

    // next state and command
    always_comb begin
        n_state  = r_state;
        o_cmd.op = OP_NONE;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (i_in_mode == MODE_ARRIVE) begin
                        o_cmd.op = OP_ARRIVE;
                        n_state  = S_OUT;
                    end else begin
                        o_cmd.op = OP_MOD_INIT;
                        n_state  = S_MOD;
                    end
                end
            end
            S_MOD: begin
                if (i_status.mod_done) n_state = S_BOOST;
                else o_cmd.op = OP_MOD_STEP;
            end
            S_BOOST: begin
                if (i_status.boost && (i_status.nonempty[1] || i_status.nonempty[2])) begin
                    o_cmd.op = OP_BOOST_RD;
                    n_state  = S_BWR;
                end else begin
                    if (i_status.boost) o_cmd.op = OP_BOOST_FIX;
                    n_state = S_PRE;
                end
            end
            S_BWR: begin
                o_cmd.op = OP_BOOST_WR;
                n_state  = S_BOOST;
            end
            S_PRE: begin
                o_cmd.op = OP_PREEMPT;
                n_state  = S_PICK;
            end
            S_PICK: begin
                if (!i_status.run_valid && (i_status.nonempty != '0)) begin
                    o_cmd.op = OP_PICK_RD;
                    n_state  = S_PLD;
                end else begin
                    n_state = S_WRD;
                end
            end
            S_PLD: begin
                o_cmd.op = OP_PICK_LD;
                n_state  = S_WRD;
            end
            S_WRD: begin
                o_cmd.op = OP_WL_RD;
                n_state  = S_RUN;
            end
            S_RUN: begin
                o_cmd.op = OP_RUN;
                n_state  = S_OUT;
            end
            S_OUT: begin
                if (i_status.out_free) begin
                    o_cmd.op = OP_OUT_LOAD;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else r_state <= n_state;
    end

endmodule

// ===== hdl/mlfq_dp.sv =====
// queues, process table, boost divider and result register of the scheduler
module mlfq_dp import mlfq_pkg::*; #(
    parameter int MAX_PROCESSES = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cmd                  i_cmd,
    output t_status               o_status,
    input  logic [ID_W-1:0]       i_proc_id,
    input  logic [BURST_W-1:0]    i_burst,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_m_tready,
    output logic                  o_m_tvalid,
    output logic [M_DATA_W-1:0]   o_m_tdata
);

    localparam int IW    = $clog2(MAX_PROCESSES);
    localparam int CW    = $clog2(MAX_PROCESSES + 1);
    localparam int TW    = IW + 1;
    localparam int SLOTS = NUM_LEVELS * MAX_PROCESSES;
    localparam int SA_W  = $clog2(SLOTS);

    // configuration
    logic [SLICE_W-1:0] r_slice0, r_slice1, r_slice2;
    logic [TICK_W-1:0]  r_boost_per;

    // queue and runner state
    logic [IW-1:0]            r_head  [NUM_LEVELS];
    logic [IW-1:0]            n_head  [NUM_LEVELS];
    logic [CW-1:0]            r_count [NUM_LEVELS];
    logic [CW-1:0]            n_count [NUM_LEVELS];
    logic [MAX_PROCESSES-1:0] r_active, n_active;
    logic                     r_run_valid, n_run_valid;
    logic [IW-1:0]            r_run_id, n_run_id;
    logic [LVL_W-1:0]         r_run_lvl, n_run_lvl;
    logic [SLICE_W-1:0]       r_slice_used, n_slice_used;
    logic [TICK_W-1:0]        r_tick, n_tick;
    logic                     r_pre, n_pre;
    t_result                  r_res, n_res;

    // boost remainder unit
    logic [TICK_W-1:0]    r_mod_rem, n_mod_rem;
    logic [TICK_W-1:0]    r_mod_div, n_mod_div;
    logic [MOD_CNT_W-1:0] r_mod_cnt, n_mod_cnt;

    // memories
    logic [IW-1:0]      r_slot_mem [SLOTS];
    logic [IW-1:0]      r_slot_rd;
    logic [BURST_W-1:0] r_work_mem [MAX_PROCESSES];
    logic [BURST_W-1:0] r_work_rd;

    logic               w_slot_we, w_work_we;
    logic [SA_W-1:0]    w_slot_waddr, w_slot_raddr;
    logic [IW-1:0]      w_slot_wdata;
    logic [IW-1:0]      w_work_waddr;
    logic [BURST_W-1:0] w_work_wdata;

    logic                  r_m_valid;
    t_result               r_m_data;
    logic [NUM_LEVELS-1:0] w_ne;
    logic [IW-1:0]         w_tail [NUM_LEVELS];
    logic                  w_boost;
    logic [LVL_W-1:0]      w_lv_b, w_lv_p;
    logic [IW-1:0]         w_id;
    logic                  w_arr_ok;
    logic [TICK_W:0]       w_mod_t;
    logic [BURST_W-1:0]    w_wl;
    logic [SLICE_W-1:0]    w_su;
    logic [LVL_W-1:0]      w_nl;
    logic                  w_pre_hit;

    function automatic logic [SA_W-1:0] slot_addr(logic [LVL_W-1:0] lv, logic [IW-1:0] idx);
        return SA_W'(SA_W'(lv) * SA_W'(MAX_PROCESSES) + SA_W'(idx));
    endfunction

    function automatic logic [IW-1:0] wrap_inc(logic [IW-1:0] h);
        return (32'(h) == MAX_PROCESSES - 1) ? '0 : IW'(h + 1'b1);
    endfunction

    function automatic logic [SLICE_W-1:0] slice_of(logic [LVL_W-1:0] lv,
            logic [SLICE_W-1:0] s0, logic [SLICE_W-1:0] s1, logic [SLICE_W-1:0] s2);
        logic [SLICE_W-1:0] s;
        s = (lv == LVL0) ? s0 : (lv == LVL1) ? s1 : s2;
        return (s == '0) ? SLICE_W'(1) : s;
    endfunction

    // queue tails and level status
    always_comb begin
        for (int l = 0; l < NUM_LEVELS; l++) begin
            logic [TW-1:0] sum;
            sum = TW'(r_head[l]) + TW'(r_count[l]);
            if (32'(sum) >= MAX_PROCESSES) sum = TW'(sum - TW'(MAX_PROCESSES));
            w_tail[l] = IW'(sum);
            w_ne[l]   = (r_count[l] != '0);
        end
    end

    assign w_boost  = (r_boost_per != '0) && (r_tick != '0) && (r_mod_rem == '0);
    assign w_lv_b   = w_ne[1] ? LVL1 : LVL2;
    assign w_lv_p   = w_ne[0] ? LVL0 : (w_ne[1] ? LVL1 : LVL2);
    assign w_id     = IW'(i_proc_id);
    assign w_arr_ok = (32'(i_proc_id) < MAX_PROCESSES) && (i_burst != '0) && !r_active[w_id];
    assign w_mod_t  = {r_mod_rem, r_mod_div[TICK_W-1]};
    assign w_wl     = r_work_rd - 1'b1;
    assign w_su     = r_slice_used + 1'b1;
    assign w_nl     = (r_run_lvl == LVL2) ? LVL2 : LVL_W'(r_run_lvl + 1'b1);
    assign w_pre_hit = r_run_valid && (((r_run_lvl == LVL1) && w_ne[0]) ||
                       ((r_run_lvl == LVL2) && (w_ne[0] || w_ne[1])));
    assign w_slot_raddr = (i_cmd.op == OP_PICK_RD) ? slot_addr(w_lv_p, r_head[w_lv_p])
                                                   : slot_addr(w_lv_b, r_head[w_lv_b]);

    // operation decoder
    always_comb begin
        n_head       = r_head;
        n_count      = r_count;
        n_active     = r_active;
        n_run_valid  = r_run_valid;
        n_run_id     = r_run_id;
        n_run_lvl    = r_run_lvl;
        n_slice_used = r_slice_used;
        n_tick       = r_tick;
        n_pre        = r_pre;
        n_res        = r_res;
        n_mod_rem    = r_mod_rem;
        n_mod_div    = r_mod_div;
        n_mod_cnt    = r_mod_cnt;
        w_slot_we    = 1'b0;
        w_slot_waddr = slot_addr(LVL0, w_tail[0]);
        w_slot_wdata = r_slot_rd;
        w_work_we    = 1'b0;
        w_work_waddr = r_run_id;
        w_work_wdata = w_wl;
        unique case (i_cmd.op)
            OP_ARRIVE: begin
                n_res           = '0;
                n_res.tick_time = r_tick;
                if (w_arr_ok) begin
                    n_res.accepted   = 1'b1;
                    n_active[w_id]   = 1'b1;
                    w_work_we        = 1'b1;
                    w_work_waddr     = w_id;
                    w_work_wdata     = i_burst;
                    w_slot_we        = 1'b1;
                    w_slot_wdata     = w_id;
                    n_count[0]       = CW'(r_count[0] + 1'b1);
                end
            end
            OP_MOD_INIT: begin
                n_mod_rem = '0;
                n_mod_div = r_tick;
                n_mod_cnt = '0;
                n_pre     = 1'b0;
            end
            OP_MOD_STEP: begin
                if (w_mod_t >= {1'b0, r_boost_per})
                    n_mod_rem = TICK_W'(w_mod_t - {1'b0, r_boost_per});
                else
                    n_mod_rem = w_mod_t[TICK_W-1:0];
                n_mod_div = {r_mod_div[TICK_W-2:0], 1'b0};
                n_mod_cnt = MOD_CNT_W'(r_mod_cnt + 1'b1);
            end
            OP_BOOST_RD: begin
                n_head[w_lv_b]  = wrap_inc(r_head[w_lv_b]);
                n_count[w_lv_b] = CW'(r_count[w_lv_b] - 1'b1);
            end
            OP_BOOST_WR: begin
                w_slot_we  = 1'b1;
                n_count[0] = CW'(r_count[0] + 1'b1);
            end
            OP_BOOST_FIX: begin
                if (r_run_valid && (r_run_lvl != LVL0)) begin
                    n_run_lvl    = LVL0;
                    n_slice_used = '0;
                end
            end
            OP_PREEMPT: begin
                if (w_pre_hit) begin
                    w_slot_we          = 1'b1;
                    w_slot_waddr       = slot_addr(r_run_lvl, w_tail[r_run_lvl]);
                    w_slot_wdata       = r_run_id;
                    n_count[r_run_lvl] = CW'(r_count[r_run_lvl] + 1'b1);
                    n_run_valid        = 1'b0;
                    n_slice_used       = '0;
                    n_pre              = 1'b1;
                end
            end
            OP_PICK_RD: begin
                n_head[w_lv_p]  = wrap_inc(r_head[w_lv_p]);
                n_count[w_lv_p] = CW'(r_count[w_lv_p] - 1'b1);
                n_run_lvl       = w_lv_p;
                n_run_valid     = 1'b1;
                n_slice_used    = '0;
            end
            OP_PICK_LD: n_run_id = r_slot_rd;
            OP_WL_RD: begin
            end
            OP_RUN: begin
                n_res           = '0;
                n_res.accepted  = 1'b1;
                n_res.preempted = r_pre;
                n_res.boosted   = w_boost;
                n_res.tick_time = r_tick;
                n_tick          = TICK_W'(r_tick + 1'b1);
                if (r_run_valid) begin
                    n_res.cpu_busy  = 1'b1;
                    n_res.run_id    = ID_W'(r_run_id);
                    n_res.run_level = r_run_lvl;
                    w_work_we       = 1'b1;
                    n_slice_used    = w_su;
                    if (w_wl == '0) begin
                        n_res.finished     = 1'b1;
                        n_active[r_run_id] = 1'b0;
                        n_run_valid        = 1'b0;
                        n_slice_used       = '0;
                    end else if (w_su >= slice_of(r_run_lvl, r_slice0, r_slice1, r_slice2)) begin
                        n_res.demoted = 1'b1;
                        n_run_lvl     = w_nl;
                        w_slot_we     = 1'b1;
                        w_slot_waddr  = slot_addr(w_nl, w_tail[w_nl]);
                        w_slot_wdata  = r_run_id;
                        n_count[w_nl] = CW'(r_count[w_nl] + 1'b1);
                        n_run_valid   = 1'b0;
                        n_slice_used  = '0;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int l = 0; l < NUM_LEVELS; l++) begin
                r_head[l]  <= '0;
                r_count[l] <= '0;
            end
            r_active     <= '0;
            r_run_valid  <= 1'b0;
            r_run_id     <= '0;
            r_run_lvl    <= LVL0;
            r_slice_used <= '0;
            r_tick       <= '0;
            r_pre        <= 1'b0;
            r_mod_cnt    <= '0;
            r_slice0     <= SLICE_W'(2);
            r_slice1     <= SLICE_W'(4);
            r_slice2     <= SLICE_W'(8);
            r_boost_per  <= TICK_W'(15);
            r_m_valid    <= 1'b0;
        end else begin
            r_head       <= n_head;
            r_count      <= n_count;
            r_active     <= n_active;
            r_run_valid  <= n_run_valid;
            r_run_id     <= n_run_id;
            r_run_lvl    <= n_run_lvl;
            r_slice_used <= n_slice_used;
            r_tick       <= n_tick;
            r_pre        <= n_pre;
            r_mod_cnt    <= n_mod_cnt;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_SLICE0: r_slice0    <= i_cfg_data[SLICE_W-1:0];
                    CFG_SLICE1: r_slice1    <= i_cfg_data[SLICE_W-1:0];
                    CFG_SLICE2: r_slice2    <= i_cfg_data[SLICE_W-1:0];
                    CFG_BOOST:  r_boost_per <= i_cfg_data[TICK_W-1:0];
                    default: ;
                endcase
            end
            if (i_cmd.op == OP_OUT_LOAD) r_m_valid <= 1'b1;
            else if (i_m_tready) r_m_valid <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_res     <= n_res;
        r_mod_rem <= n_mod_rem;
        r_mod_div <= n_mod_div;
        if (i_cmd.op == OP_OUT_LOAD) r_m_data <= r_res;
    end

    // level slot memory
    always_ff @(posedge i_clk) begin
        if (w_slot_we) r_slot_mem[w_slot_waddr] <= w_slot_wdata;
        r_slot_rd <= r_slot_mem[w_slot_raddr];
    end

    // remaining work memory
    always_ff @(posedge i_clk) begin
        if (w_work_we) r_work_mem[w_work_waddr] <= w_work_wdata;
        r_work_rd <= r_work_mem[r_run_id];
    end

    assign o_status.mod_done  = (r_mod_cnt == MOD_CNT_W'(TICK_W));
    assign o_status.boost     = w_boost;
    assign o_status.nonempty  = w_ne;
    assign o_status.run_valid = r_run_valid;
    assign o_status.out_free  = !r_m_valid || i_m_tready;
    assign o_m_tvalid         = r_m_valid;
    assign o_m_tdata          = M_DATA_W'(r_m_data);

endmodule

// ===== hdl/mlfq_tick_scheduler_top.sv =====
// top level of the three-level feedback queue scheduler
//
// s channel carries one request per item: tuser 0 is a process arrival
// (proc_id, burst in tdata), tuser 1 is one scheduler tick. m channel returns
// exactly one result per request. Configuration registers (three slice
// lengths, boost period) are written through i_cfg_we/i_cfg_idx/i_cfg_data;
// the user must write them only while no request is in flight (not enforced).
// An arrival result is registered on accept and then loaded into the output
// register. A tick runs the bit-serial remainder that decides the boost
// (16 steps and a done check), then, on a boost, the boost walk that moves
// each entry by a read and a write through the slot memory, then boost
// check, preempt, pick check, pick load when a process is picked, work read,
// run and output load.
// Only one request is processed at a time; s_tready is high only while the
// sequencer is idle. The result sits in an output register, so the next
// request can be taken in the cycle after the previous result is loaded.
// Reset clears queues, the active table, the runner and the tick counter and
// restores the register defaults; the stores need no clearing pass.
// When m_tready is low the result holds and the sequencer waits with its own
// result until the output register frees.
module mlfq_tick_scheduler_top import mlfq_pkg::*; #(
    parameter int MAX_PROCESSES = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_DATA_W-1:0]   s_tdata,   // proc_id[3:0], burst[19:4], zero fill
    input  logic                  s_tuser,   // mode
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_DATA_W-1:0]   m_tdata,   // accepted, cpu_busy, run_id[5:2],
                                             // run_level[7:6], finished, demoted,
                                             // preempted, boosted, tick_time[27:12]
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cmd    w_cmd;
    t_status w_status;

    // sequencer
    mlfq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_tvalid),
        .i_in_mode  (s_tuser),
        .i_status   (w_status),
        .o_in_ready (s_tready),
        .o_cmd      (w_cmd)
    );

    // datapath
    mlfq_dp #(
        .MAX_PROCESSES (MAX_PROCESSES)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .o_status   (w_status),
        .i_proc_id  (s_tdata[ID_W-1:0]),
        .i_burst    (s_tdata[ID_W+BURST_W-1:ID_W]),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_m_tready (m_tready),
        .o_m_tvalid (m_tvalid),
        .o_m_tdata  (m_tdata)
    );

endmodule

// ===== hdl/mlfq_checker.sv =====
// port-level checker of the scheduler and its bind
module mlfq_checker import mlfq_pkg::*; (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  s_tvalid,
    input logic                  s_tready,
    input logic [S_DATA_W-1:0]   s_tdata,
    input logic                  s_tuser,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [M_DATA_W-1:0]   m_tdata,
    input logic                  i_cfg_we,
    input logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input logic [CFG_DATA_W-1:0] i_cfg_data
);

    // no result right after reset
    a_reset_quiet: assert property (@(posedge i_clk) !i_rst_n |=> !m_tvalid)
        else $error("result valid after reset");

    // one request at a time
    a_one_inflight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second request taken while one is in flight");

    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // a rejected arrival carries no run flags
    a_reject_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tdata[0] |-> m_tdata[11:1] == 11'd0)
        else $error("rejected arrival with run flags");

    // idle tick reports no runner
    a_idle_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tdata[1] |-> m_tdata[9:2] == 8'd0)
        else $error("idle result names a runner");

endmodule

bind mlfq_tick_scheduler_top mlfq_checker u_mlfq_checker (.*);
